// File: design/gso_pkg.sv
// Shared types, constants and helpers for the 3x3 Gram-Schmidt orthonormalizer.
// No dependencies; the design files take names from here by scope.
package gso_pkg;

    localparam int DIM_DEF      = 3;
    localparam int MAX_DIM      = 3;
    localparam int NEWTON_STEPS = 4;
    // Normalize search (2) + shift (1) + seed (2) + three stages per Newton step.
    localparam int RSQRT_LAT    = 5 + 3 * NEWTON_STEPS;

    localparam logic [31:0] SEED_C0   = 32'd1181116006;  // 1.1 in Q2.30
    localparam logic [31:0] SEED_C1   = 32'd161061274;   // 0.15 in Q2.30
    localparam logic [35:0] THREE_Q30 = 36'h0_C000_0000;
    localparam logic [63:0] ONE_Q28   = 64'h0000_0000_1000_0000;
    localparam logic [63:0] HALF_Q28  = 64'h0000_0000_0800_0000;

    typedef logic [MAX_DIM-1:0][MAX_DIM-1:0][31:0] t_mat;

    typedef struct packed {
        logic bad;
        t_mat m;
    } t_item;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? 32'(-x) : x;
    endfunction

    // Q.56 -> Q.28, round to nearest, halves away from zero.
    function automatic logic signed [63:0] rnd28(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + HALF_Q28) >> 28;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// File: design/gso_if.sv
// Request channels of the orthonormalizer: input matrix and result matrix.
// Depends on nothing; payload names follow the field list.
interface gso_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] in_r0c0, in_r0c1, in_r0c2;
    logic [31:0] in_r1c0, in_r1c1, in_r1c2;
    logic [31:0] in_r2c0, in_r2c1, in_r2c2;

    modport source(output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, input ready);
    modport sink(input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface gso_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_r0c0, out_r0c1, out_r0c2;
    logic [31:0] out_r1c0, out_r1c1, out_r1c2;
    logic [31:0] out_r2c0, out_r2c1, out_r2c2;
    logic        degenerate;

    modport source(output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                   out_r1c2, out_r2c0, out_r2c1, out_r2c2, degenerate, input ready);
    modport sink(input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                 out_r1c2, out_r2c0, out_r2c1, out_r2c2, degenerate, output ready);
endinterface

// File: design/gso_rsqrt.sv
// Pipelined inverse square root of a 64-bit squared length (seed plus Newton).
// Uses gso_pkg; advances when i_ce is high.
module gso_rsqrt (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_s,
    output logic [31:0] o_y,
    output logic [4:0]  o_half
);
    localparam int NS = gso_pkg::NEWTON_STEPS;

    function automatic logic [63:0] SEED_MUL(input logic [31:0] m);
        return 64'(gso_pkg::SEED_C1) * 64'(m);
    endfunction

    // stage 1: top set bit of each 16-bit chunk
    logic [63:0]      r_s1;
    logic [3:0]       r_nz1, n_nz1;
    logic [3:0][3:0]  r_pos1, n_pos1;

    always_comb begin
        for (int q = 0; q < 4; q++) begin
            n_nz1[q]  = |i_s[16*q +: 16];
            n_pos1[q] = '0;
            for (int b = 0; b < 16; b++) begin
                if (i_s[16*q + b]) n_pos1[q] = 4'(b);
            end
        end
    end

    // stage 2: even shift that brings the top bit to 63 or 62
    logic [63:0] r_s2;
    logic [5:0]  r_sh2, n_sh2;
    logic [5:0]  w_k;

    always_comb begin
        priority if (r_nz1[3]) w_k = {2'd3, r_pos1[3]};
        else if (r_nz1[2])     w_k = {2'd2, r_pos1[2]};
        else if (r_nz1[1])     w_k = {2'd1, r_pos1[1]};
        else                   w_k = {2'd0, r_pos1[0]};
        n_sh2 = (6'd63 - w_k) & 6'b111110;
    end

    // stage 3: mantissa, stage 4: seed product, stage 5: seed
    logic [31:0] r_m3, r_m4, r_m5;
    logic [4:0]  r_h3, r_h4, r_h5;
    logic [63:0] r_p4;
    logic [31:0] r_y5;
    logic [63:0] w_shl;

    assign w_shl = r_s2 << r_sh2;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s1   <= i_s;
            r_nz1  <= n_nz1;
            r_pos1 <= n_pos1;
            r_s2   <= r_s1;
            r_sh2  <= n_sh2;
            r_m3   <= w_shl[63:32];
            r_h3   <= r_sh2[5:1];
            r_p4   <= SEED_MUL(r_m3);
            r_m4   <= r_m3;
            r_h4   <= r_h3;
            r_y5   <= gso_pkg::SEED_C0 - r_p4[61:30];
            r_m5   <= r_m4;
            r_h5   <= r_h4;
        end
    end

    // Newton steps, three stages each
    logic [31:0] w_y [NS+1];
    logic [31:0] w_m [NS+1];
    logic [4:0]  w_h [NS+1];

    assign w_y[0] = r_y5;
    assign w_m[0] = r_m5;
    assign w_h[0] = r_h5;

    for (genvar i = 0; i < NS; i++) begin : g_nr
        logic [63:0] r_yy;
        logic [31:0] r_ya, r_yb, r_yc;
        logic [31:0] r_ma, r_mb, r_mc;
        logic [4:0]  r_ha, r_hb, r_hc;
        logic [35:0] r_q;
        logic [65:0] w_qp;
        logic [31:0] w_t;
        logic [63:0] w_yt;

        assign w_qp = 66'(r_yy[63:30]) * 66'(r_ma);
        assign w_t  = (r_q > gso_pkg::THREE_Q30) ? 32'd0 : 32'(gso_pkg::THREE_Q30 - r_q);
        assign w_yt = 64'(r_yb) * 64'(w_t);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_yy <= 64'(w_y[i]) * 64'(w_y[i]);
                r_ya <= w_y[i];
                r_ma <= w_m[i];
                r_ha <= w_h[i];
                r_q  <= w_qp[65:30];
                r_yb <= r_ya;
                r_mb <= r_ma;
                r_hb <= r_ha;
                r_yc <= w_yt[62:31];
                r_mc <= r_mb;
                r_hc <= r_hb;
            end
        end

        assign w_y[i+1] = r_yc;
        assign w_m[i+1] = r_mc;
        assign w_h[i+1] = r_hc;
    end

    assign o_y    = w_y[NS];
    assign o_half = w_h[NS];

endmodule

// File: design/gso_row.sv
// One row step: squared length, inverse square root, normalize, and
// projection removal from all lower-numbered rows. Uses gso_pkg and gso_rsqrt.
module gso_row #(
    parameter int ROW = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  gso_pkg::t_item i_item,
    output logic          o_vld,
    output gso_pkg::t_item o_item
);
    localparam int LAT = gso_pkg::RSQRT_LAT;

    // squares
    logic                r_v1, r_v2;
    gso_pkg::t_item      r_it1, r_it2;
    logic [2:0][63:0]    r_sq1;
    logic [63:0]         r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_it1 <= i_item;
            for (int c = 0; c < 3; c++) begin
                r_sq1[c] <= 64'(gso_pkg::mag32(i_item.m[ROW][c]))
                          * 64'(gso_pkg::mag32(i_item.m[ROW][c]));
            end
            r_it2 <= r_it1;
            r_s2  <= r_sq1[0] + r_sq1[1] + r_sq1[2];
        end
    end

    logic [31:0] w_y;
    logic [4:0]  w_half;

    gso_rsqrt u_rsqrt (
        .i_clk  (i_clk),
        .i_ce   (i_ce),
        .i_s    (r_s2),
        .o_y    (w_y),
        .o_half (w_half)
    );

    // item waits beside the inverse square root
    logic           r_dv  [LAT];
    logic           r_dz  [LAT];
    gso_pkg::t_item r_dit [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_dv[i] <= 1'b0;
        end else if (i_ce) begin
            r_dv[0] <= r_v2;
            for (int i = 1; i < LAT; i++) r_dv[i] <= r_dv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dit[0] <= r_it2;
            r_dz[0]  <= (r_s2 == 64'd0);
            for (int i = 1; i < LAT; i++) begin
                r_dit[i] <= r_dit[i-1];
                r_dz[i]  <= r_dz[i-1];
            end
        end
    end

    // normalize
    logic             r_v3, r_v4;
    logic             r_z3;
    gso_pkg::t_item   r_it3, r_it4, n_it4;
    logic [2:0][63:0] r_p3;
    logic [4:0]       r_h3;
    logic [5:0]       w_sh;
    logic [63:0]      w_r [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_ce) begin
            r_v3 <= r_dv[LAT-1];
            r_v4 <= r_v3;
        end
    end

    assign w_sh = 6'd33 - 6'(r_h3);

    always_comb begin
        n_it4     = r_it3;
        n_it4.bad = r_it3.bad | r_z3;
        for (int c = 0; c < 3; c++) begin
            w_r[c] = (r_p3[c] + (64'd1 << (w_sh - 6'd1))) >> w_sh;
            if (w_r[c] > gso_pkg::ONE_Q28) w_r[c] = gso_pkg::ONE_Q28;
            n_it4.m[ROW][c] = r_it3.m[ROW][c][31] ? 32'(-w_r[c]) : w_r[c][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_it3 <= r_dit[LAT-1];
            r_z3  <= r_dz[LAT-1];
            r_h3  <= w_half;
            for (int c = 0; c < 3; c++) begin
                r_p3[c] <= 64'(gso_pkg::mag32(r_dit[LAT-1].m[ROW][c])) * 64'(w_y);
            end
            r_it4 <= n_it4;
        end
    end

    if (ROW == 0) begin : g_last
        assign o_vld  = r_v4;
        assign o_item = r_it4;
    end else begin : g_proj
        logic                                 r_v5, r_v6, r_v7, r_v8;
        gso_pkg::t_item                       r_it5, r_it6, r_it7, r_it8, n_it8;
        logic signed [ROW-1:0][2:0][63:0]     r_pr5, r_t7;
        logic signed [ROW-1:0][34:0]          r_dot6;
        logic signed [63:0]                   w_sum [ROW];
        logic signed [63:0]                   w_dr  [ROW];
        logic signed [63:0]                   w_df;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v5 <= 1'b0;
                r_v6 <= 1'b0;
                r_v7 <= 1'b0;
                r_v8 <= 1'b0;
            end else if (i_ce) begin
                r_v5 <= r_v4;
                r_v6 <= r_v5;
                r_v7 <= r_v6;
                r_v8 <= r_v7;
            end
        end

        always_comb begin
            for (int j = 0; j < ROW; j++) begin
                w_sum[j] = r_pr5[j][0] + r_pr5[j][1] + r_pr5[j][2];
                w_dr[j]  = gso_pkg::rnd28(w_sum[j]);
            end
        end

        always_comb begin
            n_it8 = r_it7;
            w_df  = '0;
            for (int j = 0; j < ROW; j++) begin
                for (int c = 0; c < 3; c++) begin
                    w_df = 64'($signed(r_it7.m[j][c])) - gso_pkg::rnd28(r_t7[j][c]);
                    if (w_df > 64'sd2147483647)
                        n_it8.m[j][c] = 32'h7FFF_FFFF;
                    else if (w_df < -64'sd2147483648)
                        n_it8.m[j][c] = 32'h8000_0000;
                    else
                        n_it8.m[j][c] = w_df[31:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_it5 <= r_it4;
                r_it6 <= r_it5;
                r_it7 <= r_it6;
                r_it8 <= n_it8;
                for (int j = 0; j < ROW; j++) begin
                    r_dot6[j] <= w_dr[j][34:0];
                    for (int c = 0; c < 3; c++) begin
                        r_pr5[j][c] <= 64'($signed(r_it4.m[ROW][c]))
                                     * 64'($signed(r_it4.m[j][c]));
                        r_t7[j][c]  <= 64'($signed(r_dot6[j]))
                                     * 64'($signed(r_it6.m[ROW][c]));
                    end
                end
            end
        end

        assign o_vld  = r_v8;
        assign o_item = r_it8;
    end

endmodule

// File: design/gram_schmidt_orthonormalize_3x3.sv
// Top level: modified Gram-Schmidt orthonormalizer for a DIM x DIM matrix in Q3.28.
// Uses gso_pkg, gso_if (gso_in_if, gso_out_if) and gso_row.
//
//   channel | dir | payload                                  | handshake
//   i_in    | in  | in_r0c0 .. in_r2c2 (9 x s32 Q3.28)       | valid/ready
//   o_out   | out | out_r0c0 .. out_r2c2, degenerate         | valid/ready
//
// One matrix enters per cycle while the output is not stalled.
// Reset clears only valid bits. A stalled output holds the whole pipeline in place
// (single clock enable), so nothing is dropped or repeated.
module gram_schmidt_orthonormalize_3x3 #(
    parameter int DIM = gso_pkg::DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gso_in_if.sink     i_in,
    gso_out_if.source  o_out
);
    logic        w_ce;
    logic        r_vo;
    gso_pkg::t_mat r_om;
    logic        r_bad;
    logic [31:0] w_f [9];

    logic           w_vld  [DIM+1];
    gso_pkg::t_item w_item [DIM+1];

    assign w_ce       = !r_vo || o_out.ready;
    assign i_in.ready = w_ce;

    assign w_f = '{i_in.in_r0c0, i_in.in_r0c1, i_in.in_r0c2,
                   i_in.in_r1c0, i_in.in_r1c1, i_in.in_r1c2,
                   i_in.in_r2c0, i_in.in_r2c1, i_in.in_r2c2};

    // entries outside DIM x DIM read as zero and stay zero throughout
    always_comb begin
        w_item[0].bad = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_item[0].m[r][c] = (r < DIM && c < DIM) ? w_f[r*3 + c] : 32'd0;
            end
        end
    end
    assign w_vld[0] = i_in.valid;

    for (genvar k = 0; k < DIM; k++) begin : g_row
        gso_row #(.ROW(DIM - 1 - k)) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_vld   (w_vld[k]),
            .i_item  (w_item[k]),
            .o_vld   (w_vld[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_ce) begin
            r_vo <= w_vld[DIM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_bad <= w_item[DIM].bad;
            r_om  <= w_item[DIM].bad ? '0 : w_item[DIM].m;
        end
    end

    assign o_out.valid      = r_vo;
    assign o_out.degenerate = r_bad;
    assign o_out.out_r0c0   = r_om[0][0];
    assign o_out.out_r0c1   = r_om[0][1];
    assign o_out.out_r0c2   = r_om[0][2];
    assign o_out.out_r1c0   = r_om[1][0];
    assign o_out.out_r1c1   = r_om[1][1];
    assign o_out.out_r1c2   = r_om[1][2];
    assign o_out.out_r2c0   = r_om[2][0];
    assign o_out.out_r2c1   = r_om[2][1];
    assign o_out.out_r2c2   = r_om[2][2];

endmodule

// File: design/gso_chk.sv
// Port-level checks for the orthonormalizer, bound to the top level.
// Uses gso_if only.
module gso_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    gso_in_if.sink    i_in,
    gso_out_if.source o_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid)
        else $error("result dropped while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input blocked with empty output");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
        (o_out.out_r0c0 == 32'd0 && o_out.out_r0c1 == 32'd0 && o_out.out_r0c2 == 32'd0 &&
         o_out.out_r1c0 == 32'd0 && o_out.out_r1c1 == 32'd0 && o_out.out_r1c2 == 32'd0 &&
         o_out.out_r2c0 == 32'd0 && o_out.out_r2c1 == 32'd0 && o_out.out_r2c2 == 32'd0))
        else $error("degenerate result not zero");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        ($signed(o_out.out_r0c0) <= 32'sd268435456 && $signed(o_out.out_r0c0) >= -32'sd268435456 &&
         $signed(o_out.out_r0c1) <= 32'sd268435456 && $signed(o_out.out_r0c1) >= -32'sd268435456 &&
         $signed(o_out.out_r0c2) <= 32'sd268435456 && $signed(o_out.out_r0c2) >= -32'sd268435456))
        else $error("normalized entry above 1.0");

endmodule

bind gram_schmidt_orthonormalize_3x3 gso_chk u_gso_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
